>>> hw/rtl/bced_pkg.sv
// Shared types and constants for the button click event detector.
// Payload structs, controller/datapath command and status, event codes.
`timescale 1ns / 1ps

package bced_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned TickWidth     = 16;
   localparam int unsigned ModStepWidth  = 4;

   localparam logic [7:0]  ShortTicksReset  = 8'd30;
   localparam logic [15:0] LongTicksReset   = 16'd50;
   localparam logic [7:0]  HoldPeriodReset  = 8'd20;
   localparam logic        ActiveLevelReset = 1'b0;

   localparam logic [CsrIndexWidth-1:0] CsrShortTicks  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrLongTicks   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrHoldPeriod  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrActiveLevel = 2'd3;

   localparam logic [2:0] EvNone   = 3'd0;
   localparam logic [2:0] EvDown   = 3'd1;
   localparam logic [2:0] EvUp     = 3'd2;
   localparam logic [2:0] EvSingle = 3'd3;
   localparam logic [2:0] EvDouble = 3'd4;
   localparam logic [2:0] EvLong   = 3'd5;
   localparam logic [2:0] EvHold   = 3'd6;

   localparam logic ReqScan      = 1'b0;
   localparam logic ReqSoftReset = 1'b1;

   typedef struct packed {
      logic req_type;
      logic pin_level;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       event_fired;
      logic [2:0] press_state;
      logic       stable_level;
   } rsp_beat_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mod_load;
      logic mod_step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic is_soft;
      logic need_mod;
   } dp_status_type;

endpackage

>>> hw/rtl/bced_ctrl.sv
// Sequencer for one beat: prepare, optional 16-step remainder, finish, deliver.
// Depends on bced_pkg.
`timescale 1ns / 1ps

module bced_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bced_pkg::dp_status_type status,
   output bced_pkg::dp_cmd_type   cmd
);
   import bced_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_CHECK,
      S_MOD,
      S_FINISH,
      S_OUT
   } ctrl_state_type;

   ctrl_state_type             state_ff, state_in;
   logic [ModStepWidth-1:0]    step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PREP;
         end
         S_PREP: begin
            state_in = status.is_soft ? S_OUT : S_CHECK;
         end
         S_CHECK: begin
            step_in  = '0;
            state_in = status.need_mod ? S_MOD : S_FINISH;
         end
         S_MOD: begin
            step_in = step_ff + 1'b1;
            if (step_ff == {ModStepWidth{1'b1}}) state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.prep     = (state_ff == S_PREP);
      cmd.mod_load = (state_ff == S_CHECK) && status.need_mod;
      cmd.mod_step = (state_ff == S_MOD);
      cmd.finish   = (state_ff == S_FINISH);
   end

endmodule

>>> hw/rtl/bced_dp.sv
// Datapath: timing registers, debouncer, detector state, shift-subtract remainder
// unit and the result register. Depends on bced_pkg.
`timescale 1ns / 1ps

module bced_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [bced_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [bced_pkg::CsrDataWidth-1:0]      csr_wdata,
   input  bced_pkg::req_beat_type                 req_data,
   input  bced_pkg::dp_cmd_type                   cmd,
   output bced_pkg::dp_status_type                status,
   output bced_pkg::rsp_beat_type                 rsp_data
);
   import bced_pkg::*;

   typedef enum logic [2:0] {
      D_IDLE     = 3'd0,
      D_PRESSED  = 3'd1,
      D_RELEASED = 3'd2,
      D_REPRESS  = 3'd3,
      D_LONG     = 3'd4
   } det_state_type;

   logic [7:0]           short_ff;
   logic [15:0]          long_ff;
   logic [7:0]           hold_ff;
   logic                 active_ff;

   req_beat_type         req_ff;
   det_state_type        mst_ff, mst_in;
   logic [TickWidth-1:0] tick_ff, tick_in;
   logic [1:0]           dcnt_ff, dcnt_in;
   logic                 deb_ff, deb_in;
   logic [7:0]           click_ff, click_in;
   logic [2:0]           last_ff, last_in;
   logic [TickWidth-1:0] div_ff;
   logic [7:0]           rem_ff;
   logic [8:0]           rem_shift;
   rsp_beat_type         rsp_ff, rsp_in;
   logic                 fired;
   logic                 pressed;
   logic [1:0]           dcnt_inc;

   assign pressed = (deb_ff == active_ff);

   assign status = '{is_soft:  (req_ff.req_type == ReqSoftReset),
                     need_mod: (mst_ff == D_LONG) && pressed && (hold_ff != 8'd0)};

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= ShortTicksReset;
         long_ff   <= LongTicksReset;
         hold_ff   <= HoldPeriodReset;
         active_ff <= ActiveLevelReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrShortTicks:  short_ff  <= csr_wdata[7:0];
            CsrLongTicks:   long_ff   <= csr_wdata;
            CsrHoldPeriod:  hold_ff   <= csr_wdata[7:0];
            CsrActiveLevel: active_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // remainder unit: one dividend bit per step
   assign rem_shift = {rem_ff, div_ff[TickWidth-1]};

   always_ff @(posedge clock) begin
      if (cmd.mod_load) begin
         div_ff <= tick_ff;
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         div_ff <= {div_ff[TickWidth-2:0], 1'b0};
         rem_ff <= (rem_shift >= {1'b0, hold_ff}) ? 8'(rem_shift - {1'b0, hold_ff})
                                                 : rem_shift[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   assign dcnt_inc = dcnt_ff + 2'd1;

   always_comb begin
      mst_in   = mst_ff;
      tick_in  = tick_ff;
      dcnt_in  = dcnt_ff;
      deb_in   = deb_ff;
      click_in = click_ff;
      last_in  = last_ff;
      fired    = 1'b0;
      rsp_in   = rsp_ff;
      if (cmd.prep) begin
         if (req_ff.req_type == ReqSoftReset) begin
            mst_in   = D_IDLE;
            tick_in  = '0;
            dcnt_in  = '0;
            click_in = '0;
            last_in  = EvNone;
            rsp_in   = '{event_code: EvNone, event_fired: 1'b0,
                         press_state: D_IDLE, stable_level: deb_ff};
         end else begin
            if (mst_ff != D_IDLE) tick_in = tick_ff + 1'b1;
            if (req_ff.pin_level != deb_ff) begin
               dcnt_in = dcnt_inc;
               if (dcnt_inc >= 2'd2) begin
                  deb_in  = req_ff.pin_level;
                  dcnt_in = '0;
               end
            end else begin
               dcnt_in = '0;
            end
         end
      end else if (cmd.finish) begin
         unique case (mst_ff)
            D_IDLE: begin
               if (pressed) begin
                  fired    = 1'b1;
                  last_in  = EvDown;
                  tick_in  = '0;
                  click_in = 8'd1;
                  mst_in   = D_PRESSED;
               end else begin
                  last_in = EvNone;
               end
            end
            D_PRESSED: begin
               if (!pressed) begin
                  fired   = 1'b1;
                  last_in = EvUp;
                  tick_in = '0;
                  mst_in  = D_RELEASED;
               end else if (long_ff != 16'd0 && tick_ff > long_ff) begin
                  fired   = 1'b1;
                  last_in = EvLong;
                  mst_in  = D_LONG;
               end
            end
            D_RELEASED: begin
               if (pressed) begin
                  fired    = 1'b1;
                  last_in  = EvDown;
                  click_in = click_ff + 8'd1;
                  tick_in  = '0;
                  mst_in   = D_REPRESS;
               end else if (tick_ff > {8'd0, short_ff}) begin
                  if (click_ff == 8'd1) begin
                     fired   = 1'b1;
                     last_in = EvSingle;
                  end else if (click_ff == 8'd2) begin
                     fired   = 1'b1;
                     last_in = EvDouble;
                  end
                  mst_in = D_IDLE;
               end
            end
            D_REPRESS: begin
               if (!pressed) begin
                  fired   = 1'b1;
                  last_in = EvUp;
                  if (tick_ff < {8'd0, short_ff}) begin
                     tick_in = '0;
                     mst_in  = D_RELEASED;
                  end else begin
                     mst_in = D_IDLE;
                  end
               end
            end
            D_LONG: begin
               if (pressed) begin
                  if (hold_ff != 8'd0 && rem_ff == 8'd0) begin
                     fired   = 1'b1;
                     last_in = EvHold;
                  end
               end else begin
                  fired   = 1'b1;
                  last_in = EvUp;
                  mst_in  = D_IDLE;
               end
            end
            default: mst_in = D_IDLE;
         endcase
         rsp_in = '{event_code: last_in, event_fired: fired,
                    press_state: mst_in, stable_level: deb_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mst_ff   <= D_IDLE;
         tick_ff  <= '0;
         dcnt_ff  <= '0;
         deb_ff   <= ~ActiveLevelReset;
         click_ff <= '0;
         last_ff  <= EvNone;
      end else begin
         mst_ff   <= mst_in;
         tick_ff  <= tick_in;
         dcnt_ff  <= dcnt_in;
         deb_ff   <= deb_in;
         click_ff <= click_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/button_click_event_detector_core.sv
// Top level of the button click event detector: sequencer plus datapath.
// Depends on bced_pkg, bced_ctrl, bced_dp.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   bced_pkg::req_beat_type
//   rsp_     out        rsp_valid/rsp_stall   bced_pkg::rsp_beat_type
//   csr_     in         csr_we                csr_index, csr_wdata
//
// One beat at a time: accept, prepare, check, then finish and deliver. While in long
// press with the button still down and a nonzero hold period, the 16-step shift-subtract
// remainder unit runs between check and finish. Soft reset beats skip check and finish.
// Synchronous reset restores the registers to 30, 50, 20, 0 and clears the detector.
// req_stall stays high until the result beat is taken; rsp_stall holds the result.
`timescale 1ns / 1ps

module button_click_event_detector_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bced_pkg::req_beat_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bced_pkg::rsp_beat_type             rsp_data,
   input  logic                               csr_we,
   input  logic [bced_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bced_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import bced_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bced_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bced_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sim/testbench.sv
// Self-checking testbench for button_click_event_detector_core: a directed table, then
// random press/release gestures checked beat by beat against a debounce/click predictor.
// Depends on bced_pkg and the RTL of the detector core.
`timescale 1ns / 1ps

module testbench;
   import bced_pkg::*;

   localparam int unsigned RandomBeats = 700;
   localparam int unsigned PhaseBeats  = 150;
   localparam int unsigned CycleLimit  = 4000000;

   typedef enum logic [2:0] {
      PsIdle     = 3'd0,
      PsPressed  = 3'd1,
      PsReleased = 3'd2,
      PsRepress  = 3'd3,
      PsLong     = 3'd4
   } press_state_type;

   typedef enum logic {RowBeat, RowCsr} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      req_beat_type             beat;
      logic [CsrIndexWidth-1:0] idx;
      logic [CsrDataWidth-1:0]  value;
      logic                     typed;
      rsp_beat_type             exp;
   } plan_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_beat_type             req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_beat_type             rsp_data;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   // predictor copy of the registers and detector state
   logic [7:0]      cfg_short;
   logic [15:0]     cfg_long;
   logic [7:0]      cfg_hold;
   logic            cfg_active;
   press_state_type ps;
   logic [15:0]     ticks;
   logic [1:0]      bounce;
   logic            level;
   logic [7:0]      clicks;
   logic [2:0]      latched;

   rsp_beat_type pending[$];
   int unsigned  mismatch_count;
   int unsigned  cycle_count;
   int unsigned  beats_sent;
   bit           calm;

   button_click_event_detector_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("button_click_event_detector_core verification failed");
         $finish;
      end
   end

   function automatic rsp_beat_type detect_tick(input req_beat_type b);
      rsp_beat_type r;
      logic         fired;
      logic         down;
      fired = 1'b0;
      if (b.req_type == ReqSoftReset) begin
         ps = PsIdle;
         ticks = 16'd0;
         bounce = 2'd0;
         clicks = 8'd0;
         latched = EvNone;
      end else begin
         if (ps != PsIdle)
            ticks = ticks + 16'd1;
         if (b.pin_level != level) begin
            bounce = bounce + 2'd1;
            if (bounce >= 2'd2) begin
               level = b.pin_level;
               bounce = 2'd0;
            end
         end else begin
            bounce = 2'd0;
         end
         down = (level == cfg_active);
         case (ps)
            PsIdle: begin
               if (down) begin
                  latched = EvDown;
                  fired = 1'b1;
                  ticks = 16'd0;
                  clicks = 8'd1;
                  ps = PsPressed;
               end else begin
                  latched = EvNone;
               end
            end
            PsPressed: begin
               if (!down) begin
                  latched = EvUp;
                  fired = 1'b1;
                  ticks = 16'd0;
                  ps = PsReleased;
               end else if (cfg_long != 16'd0 && ticks > cfg_long) begin
                  latched = EvLong;
                  fired = 1'b1;
                  ps = PsLong;
               end
            end
            PsReleased: begin
               if (down) begin
                  latched = EvDown;
                  fired = 1'b1;
                  clicks = clicks + 8'd1;
                  ticks = 16'd0;
                  ps = PsRepress;
               end else if (ticks > {8'd0, cfg_short}) begin
                  // three or more clicks end silently
                  if (clicks == 8'd1) begin
                     latched = EvSingle;
                     fired = 1'b1;
                  end else if (clicks == 8'd2) begin
                     latched = EvDouble;
                     fired = 1'b1;
                  end
                  ps = PsIdle;
               end
            end
            PsRepress: begin
               if (!down) begin
                  latched = EvUp;
                  fired = 1'b1;
                  if (ticks < {8'd0, cfg_short}) begin
                     ticks = 16'd0;
                     ps = PsReleased;
                  end else begin
                     ps = PsIdle;
                  end
               end
            end
            PsLong: begin
               if (down) begin
                  if (cfg_hold != 8'd0 && (ticks % {8'd0, cfg_hold}) == 16'd0) begin
                     latched = EvHold;
                     fired = 1'b1;
                  end
               end else begin
                  latched = EvUp;
                  fired = 1'b1;
                  ps = PsIdle;
               end
            end
            default: ps = PsIdle;
         endcase
      end
      r.event_code = latched;
      r.event_fired = fired;
      r.press_state = ps;
      r.stable_level = level;
      return r;
   endfunction

   task automatic note_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s at cycle %0d: expected %0h, actual %0h",
                  field, cycle_count, want, got);
   endtask

   always @(posedge clock) begin : result_check
      rsp_beat_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending.size() == 0) begin
            note_mismatch("unexpected beat", 16'd0, {8'd0, rsp_data});
         end else begin
            want = pending.pop_front();
            if (rsp_data.event_code !== want.event_code)
               note_mismatch("event_code", 16'(want.event_code),
                             16'(rsp_data.event_code));
            if (rsp_data.event_fired !== want.event_fired)
               note_mismatch("event_fired", 16'(want.event_fired),
                             16'(rsp_data.event_fired));
            if (rsp_data.press_state !== want.press_state)
               note_mismatch("press_state", 16'(want.press_state),
                             16'(rsp_data.press_state));
            if (rsp_data.stable_level !== want.stable_level)
               note_mismatch("stable_level", 16'(want.stable_level),
                             16'(rsp_data.stable_level));
         end
      end
   end

   initial begin : result_taker
      int unsigned hold_off;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold_off = calm ? 0 : $urandom_range(0, 16);
         if (hold_off != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input req_beat_type b, input logic typed,
                            input rsp_beat_type sure);
      int unsigned  gap;
      rsp_beat_type want;
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_data <= req_beat_type'(2'($urandom_range(0, 3)));
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = detect_tick(b);
      pending.push_back(typed ? sure : want);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CsrShortTicks:  cfg_short = value[7:0];
         CsrLongTicks:   cfg_long = value;
         CsrHoldPeriod:  cfg_hold = value[7:0];
         CsrActiveLevel: cfg_active = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_timing(input logic [7:0] st, input logic [15:0] lt,
                                 input logic [7:0] hp, input logic al);
      logic [15:0] junk;
      settle();
      junk = 16'($urandom);
      write_reg(CsrShortTicks, {junk[15:8], st});
      write_reg(CsrLongTicks, lt);
      write_reg(CsrHoldPeriod, {junk[7:0], hp});
      write_reg(CsrActiveLevel, {junk[14:0], al});
   endtask

   task automatic tap(input logic lvl, input int unsigned count, input bit shaky);
      req_beat_type b;
      repeat (count) begin
         b.req_type = ReqScan;
         b.pin_level = lvl ^ (shaky && $urandom_range(0, 15) == 0);
         send_beat(b, 1'b0, '0);
      end
   endtask

   task automatic soft_clear();
      req_beat_type b;
      b.req_type = ReqSoftReset;
      b.pin_level = 1'($urandom_range(0, 1));
      send_beat(b, 1'b0, '0);
   endtask

   task automatic gesture();
      int unsigned pick;
      int unsigned press_len;
      int unsigned gap_len;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         soft_clear();
      end else if (pick < 13) begin
         repeat ($urandom_range(1, 8)) tap(1'($urandom_range(0, 1)), 1, 1'b0);
      end else begin
         press_len = $urandom_range(1, 6);
         if ($urandom_range(0, 4) == 0)
            press_len = cfg_long + $urandom_range(0, 3 * cfg_hold + 6);
         if (press_len > 400)
            press_len = 400;
         gap_len = $urandom_range(1, cfg_short + 4);
         tap(cfg_active, press_len, 1'b1);
         tap(!cfg_active, gap_len, 1'b1);
      end
   endtask

   // 258 quick clicks wrap the click counter back to two
   task automatic click_storm();
      logic al;
      calm = 1'b1;
      al = 1'($urandom_range(0, 1));
      program_timing(8'd255, 16'd0, 8'($urandom_range(0, 8)), al);
      soft_clear();
      tap(!al, 3, 1'b0);
      repeat (258) begin
         tap(al, 2, 1'b0);
         tap(!al, 2, 1'b0);
      end
      tap(!al, 258, 1'b0);
   endtask

   function automatic plan_row_type beat_row(input logic rtype, input logic pin);
      plan_row_type r;
      r = '0;
      r.kind = RowBeat;
      r.beat.req_type = rtype;
      r.beat.pin_level = pin;
      return r;
   endfunction

   function automatic plan_row_type sure_row(input logic rtype, input logic pin,
                                             input logic [2:0] ev, input logic fired,
                                             input logic [2:0] st, input logic lvl);
      plan_row_type r;
      r = beat_row(rtype, pin);
      r.typed = 1'b1;
      r.exp.event_code = ev;
      r.exp.event_fired = fired;
      r.exp.press_state = st;
      r.exp.stable_level = lvl;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CsrIndexWidth-1:0] idx,
                                            input logic [CsrDataWidth-1:0] value);
      plan_row_type r;
      r = '0;
      r.kind = RowCsr;
      r.idx = idx;
      r.value = value;
      return r;
   endfunction

   initial begin : stimulus
      plan_row_type plan [24];
      int unsigned  random_count;
      int unsigned  phase_start;
      int unsigned  mark;
      int unsigned  phase_no;
      logic [7:0]   st;
      logic [15:0]  lt;
      logic [7:0]   hp;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      beats_sent = 0;
      cfg_short = ShortTicksReset;
      cfg_long = LongTicksReset;
      cfg_hold = HoldPeriodReset;
      cfg_active = ActiveLevelReset;
      ps = PsIdle;
      ticks = 16'd0;
      bounce = 2'd0;
      level = ~ActiveLevelReset;
      clicks = 8'd0;
      latched = EvNone;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      plan = '{
         sure_row(ReqScan, 1'b1, EvNone, 1'b0, PsIdle, 1'b1),
         sure_row(ReqScan, 1'b0, EvNone, 1'b0, PsIdle, 1'b1),
         sure_row(ReqScan, 1'b0, EvDown, 1'b1, PsPressed, 1'b0),
         sure_row(ReqSoftReset, 1'b1, EvNone, 1'b0, PsIdle, 1'b0),
         csr_row(CsrShortTicks, 16'hFF00),
         csr_row(CsrLongTicks, 16'h0001),
         csr_row(CsrHoldPeriod, 16'hAB01),
         sure_row(ReqScan, 1'b0, EvDown, 1'b1, PsPressed, 1'b0),
         beat_row(ReqScan, 1'b0),
         beat_row(ReqScan, 1'b0),
         beat_row(ReqScan, 1'b0),
         beat_row(ReqScan, 1'b1),
         beat_row(ReqScan, 1'b1),
         beat_row(ReqScan, 1'b0),
         beat_row(ReqScan, 1'b0),
         beat_row(ReqScan, 1'b1),
         beat_row(ReqScan, 1'b1),
         beat_row(ReqScan, 1'b1),
         csr_row(CsrActiveLevel, 16'hFFFF),
         beat_row(ReqScan, 1'b1),
         csr_row(CsrShortTicks, 16'h00FF),
         csr_row(CsrLongTicks, 16'hFFFF),
         csr_row(CsrHoldPeriod, 16'h00FF),
         sure_row(ReqSoftReset, 1'b0, EvNone, 1'b0, PsIdle, 1'b1)
      };

      foreach (plan[i]) begin
         if (plan[i].kind == RowCsr) begin
            settle();
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].exp);
         end
      end

      random_count = 0;
      phase_no = 0;
      while (random_count < RandomBeats) begin
         if (phase_no == 2)
            click_storm();
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0:       st = 8'd0;
            1:       st = 8'd255;
            default: st = 8'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       lt = 16'd0;
            1:       lt = 16'd65535;
            2:       lt = 16'd1;
            default: lt = 16'($urandom_range(2, 40));
         endcase
         case ($urandom_range(0, 5))
            0:       hp = 8'd0;
            1:       hp = 8'd255;
            2:       hp = 8'd1;
            default: hp = 8'($urandom_range(2, 8));
         endcase
         program_timing(st, lt, hp, 1'($urandom_range(0, 1)));
         phase_start = random_count;
         while (random_count - phase_start < PhaseBeats) begin
            mark = beats_sent;
            gesture();
            random_count += beats_sent - mark;
         end
         phase_no++;
      end

      settle();
      repeat (32) @(negedge clock);
      if (mismatch_count == 0 && pending.size() == 0)
         $display("button_click_event_detector_core verification clean");
      else
         $display("button_click_event_detector_core verification failed");
      $finish;
   end

endmodule
